/* rtl/core/bsad_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bsad_pkg;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int RAM_W    = 17;
    localparam int ROM_W    = 14;
    localparam int SEL_W    = 2;
    localparam int TGT_W    = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // targets
    localparam logic [TGT_W-1:0] TGT_BASE = 2'd0;
    localparam logic [TGT_W-1:0] TGT_RAM  = 2'd1;
    localparam logic [TGT_W-1:0] TGT_ROM  = 2'd2;
    localparam logic [TGT_W-1:0] TGT_REG  = 2'd3;

    // rom map codes
    localparam logic [SEL_W-1:0] MAP_EPROM   = 2'd0;
    localparam logic [SEL_W-1:0] MAP_LOW_RAM = 2'd1;
    localparam logic [SEL_W-1:0] MAP_BASE    = 2'd2;
    localparam logic [SEL_W-1:0] MAP_ALL_RAM = 2'd3;

    // address map
    localparam logic [ADDR_W-1:0] ADR_LO_RAM_A   = 16'h0004;
    localparam logic [ADDR_W-1:0] ADR_LO_RAM_B   = 16'h0007;
    localparam logic [ADDR_W-1:0] ADR_LO_RAM_ONE = 16'h000F;
    localparam logic [ADDR_W-1:0] ADR_LO_RAM_C   = 16'h0020;
    localparam logic [ADDR_W-1:0] ADR_MID_LO     = 16'h4000;
    localparam logic [ADDR_W-1:0] ADR_MIRROR_END = 16'h6000;
    localparam logic [ADDR_W-1:0] ADR_MID_HI     = 16'hBEFF;
    localparam logic [ADDR_W-1:0] ADR_REG_BANK   = 16'hBF00;
    localparam logic [ADDR_W-1:0] ADR_REG_MAP    = 16'hBF01;
    localparam logic [ADDR_W-1:0] ADR_HI_LO      = 16'hC000;
    localparam logic [ADDR_W-1:0] ADR_HI_RAM_END = 16'hE000;
    localparam logic [ADDR_W-1:0] ADR_TOP_PAGE   = 16'hFF00;
    localparam logic [ADDR_W-1:0] MID_OFFSET     = 16'h4000;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic [RAM_W-1:0] ram_address;
        logic [ROM_W-1:0] rom_address;
        logic [SEL_W-1:0] read_data;
        logic             mirror_to_base;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/bank_switch_address_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// an accepted s_ word passes the input register, then the result register, before its m_ word is valid
// throughput: one word per cycle, sustained while m_tready stays high
// the decode sits in one combinational stage between the two registers
// reset (aresetn low, synchronous) empties both stages and clears the ram bank and rom map registers
module bank_switch_address_decoder
    import bsad_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [S_DATA_W-1:0]   s_tdata,   // bus_address[15:0], write_data[23:16]
    input  wire                  s_tuser,   // mode: 0 read, 1 write
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // ram_address[16:0], rom_address[30:17],
                                            // read_data[32:31], mirror_to_base[33], zero[39:34]
    output logic [TGT_W-1:0]     m_tuser    // target
);

    logic              in_valid_reg;
    logic              in_mode_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_data_reg;

    logic              out_valid_reg;
    result_t           out_reg;
    result_t           res_next;

    logic [SEL_W-1:0]  ram_bank_reg;
    logic [SEL_W-1:0]  ram_bank_next;
    logic [SEL_W-1:0]  rom_map_reg;
    logic [SEL_W-1:0]  rom_map_next;

    logic              advance;
    logic              s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        logic              wr;
        logic [ADDR_W-1:0] a;
        logic              b0;
        logic              b1;
        logic              use_ram;
        logic [ADDR_W-1:0] mid_addr;

        wr       = in_mode_reg;
        a        = in_addr_reg;
        b0       = ram_bank_reg[0];
        b1       = ram_bank_reg[1];
        mid_addr = a + MID_OFFSET;
        use_ram  = 1'b0;

        res_next      = '0;
        ram_bank_next = ram_bank_reg;
        rom_map_next  = rom_map_reg;

        if ((a >= ADR_LO_RAM_A && a <= ADR_LO_RAM_B) || a == ADR_LO_RAM_ONE
                || (a >= ADR_LO_RAM_C && a < ADR_MID_LO)) begin
            res_next.target      = TGT_RAM;
            res_next.ram_address = {b0, a};
        end else if (a >= ADR_MID_LO && a <= ADR_MID_HI) begin
            res_next.target         = TGT_RAM;
            res_next.ram_address    = {b1, mid_addr};
            res_next.mirror_to_base = wr && !b1 && (a < ADR_MIRROR_END);
        end else if (a == ADR_REG_BANK || a == ADR_REG_MAP) begin
            res_next.target = TGT_REG;
            if (wr) begin
                if (a == ADR_REG_BANK) begin
                    ram_bank_next = in_data_reg[SEL_W-1:0];
                end else begin
                    rom_map_next = in_data_reg[SEL_W-1:0];
                end
            end else begin
                res_next.read_data = (a == ADR_REG_BANK) ? ram_bank_reg : rom_map_reg;
            end
        end else if (a >= ADR_HI_LO) begin
            if (wr) begin
                use_ram = 1'b1;
            end else begin
                case (rom_map_reg)
                    MAP_EPROM:   use_ram = 1'b0;
                    MAP_ALL_RAM: use_ram = 1'b1;
                    default:     use_ram = (a < ADR_HI_RAM_END);
                endcase
            end
            if (use_ram) begin
                res_next.target = TGT_RAM;
                // a - 0x8000: top page always sits in the low half
                res_next.ram_address = {(a < ADR_TOP_PAGE) && b0, 1'b0, a[ADDR_W-2:0]};
            end else if (rom_map_reg == MAP_BASE) begin
                res_next.target = TGT_BASE;
            end else begin
                res_next.target      = TGT_ROM;
                res_next.rom_address = a[ROM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ram_bank_reg  <= '0;
            rom_map_reg   <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                ram_bank_reg  <= ram_bank_next;
                rom_map_reg   <= rom_map_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg <= s_tuser;
            in_addr_reg <= s_tdata[ADDR_W-1:0];
            in_data_reg <= s_tdata[ADDR_W+DATA_W-1:ADDR_W];
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.target;
    assign m_tdata  = {{(M_DATA_W-RAM_W-ROM_W-SEL_W-1){1'b0}}, out_reg.mirror_to_base,
                       out_reg.read_data, out_reg.rom_address, out_reg.ram_address};

    a_mirror_is_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.mirror_to_base |-> out_reg.target == TGT_RAM)
        else $error("mirror flag on a non ram word");

    a_rom_addr_only_rom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.rom_address != '0 |-> out_reg.target == TGT_ROM)
        else $error("eprom address on a non eprom word");

    a_read_data_only_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.read_data != '0 |-> out_reg.target == TGT_REG)
        else $error("register data on a non register word");

    a_regs_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(ram_bank_reg) && $stable(rom_map_reg))
        else $error("control register changed without a word passing");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bsad_pkg::*;

    typedef struct {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        bit                typed;
        result_t           res;
    } dir_row_t;

    localparam int N_DIR = 28;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [TGT_W-1:0]    m_tuser;

    // own copy of the two control registers
    logic [SEL_W-1:0] bank_sel = '0;
    logic [SEL_W-1:0] map_sel  = '0;

    result_t pending_decodes[$];
    int      gap_pct     = 0;
    int      stall_pct   = 0;
    int      hold_reqs   = 0;
    int      holds_taken = 0;
    int      hold_left   = 0;
    int      errors      = 0;
    int      words_sent  = 0;
    int      results_seen = 0;
    int      reg_writes  = 0;
    int      mirror_hits = 0;

    // rows marked 1 carry an expectation read straight off the address map
    dir_row_t dir_rows [N_DIR] = '{
        '{1'b0, 16'h0000, 8'h00, 1'b1, '{TGT_BASE, 17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'h0003, 8'h00, 1'b1, '{TGT_BASE, 17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'h0004, 8'h00, 1'b1, '{TGT_RAM,  17'h00004, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'h000F, 8'h00, 1'b1, '{TGT_RAM,  17'h0000F, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'h001F, 8'h00, 1'b1, '{TGT_BASE, 17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'h3FFF, 8'h00, 1'b1, '{TGT_RAM,  17'h03FFF, 14'h0000, 2'd0, 1'b0}},
        '{1'b1, 16'h4000, 8'hA5, 1'b1, '{TGT_RAM,  17'h08000, 14'h0000, 2'd0, 1'b1}},
        '{1'b1, 16'h5FFF, 8'h5A, 1'b1, '{TGT_RAM,  17'h09FFF, 14'h0000, 2'd0, 1'b1}},
        '{1'b1, 16'h6000, 8'hFF, 1'b1, '{TGT_RAM,  17'h0A000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hBEFF, 8'h00, 1'b1, '{TGT_RAM,  17'h0FEFF, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hBF00, 8'h00, 1'b1, '{TGT_REG,  17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hBF02, 8'h00, 1'b1, '{TGT_BASE, 17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b1, 16'hBFFF, 8'h03, 1'b1, '{TGT_BASE, 17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hC000, 8'h00, 1'b1, '{TGT_ROM,  17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hFFFF, 8'h00, 1'b1, '{TGT_ROM,  17'h00000, 14'h3FFF, 2'd0, 1'b0}},
        '{1'b1, 16'hFF00, 8'h00, 1'b1, '{TGT_RAM,  17'h07F00, 14'h0000, 2'd0, 1'b0}},
        '{1'b1, 16'hBF00, 8'hFF, 1'b1, '{TGT_REG,  17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hBF00, 8'h00, 1'b1, '{TGT_REG,  17'h00000, 14'h0000, 2'd3, 1'b0}},
        '{1'b1, 16'h4000, 8'h00, 1'b0, '0},
        '{1'b0, 16'h0080, 8'h00, 1'b0, '0},
        '{1'b1, 16'hBF01, 8'h02, 1'b1, '{TGT_REG,  17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hE000, 8'h00, 1'b1, '{TGT_BASE, 17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hC000, 8'h00, 1'b0, '0},
        '{1'b1, 16'hBF01, 8'h01, 1'b1, '{TGT_REG,  17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hE000, 8'h00, 1'b0, '0},
        '{1'b1, 16'hBF01, 8'hFF, 1'b1, '{TGT_REG,  17'h00000, 14'h0000, 2'd0, 1'b0}},
        '{1'b0, 16'hFFFF, 8'h00, 1'b0, '0},
        '{1'b1, 16'hBF00, 8'hFC, 1'b1, '{TGT_REG,  17'h00000, 14'h0000, 2'd0, 1'b0}}
    };

    bank_switch_address_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // bus_address[15:0], write_data[23:16]
        .s_tuser  (s_tuser),   // mode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // ram_address, rom_address, read_data, mirror_to_base
        .m_tuser  (m_tuser)    // target
    );

    always #5 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    // decodes one access and applies register writes to the local copy
    function automatic result_t decode_access(input logic wr, input logic [ADDR_W-1:0] a,
                                              input logic [DATA_W-1:0] d);
        result_t r;
        logic    use_ram;
        r = '0;
        r.target = TGT_BASE;
        if ((a >= ADR_LO_RAM_A && a <= ADR_LO_RAM_B) || a == ADR_LO_RAM_ONE ||
            (a >= ADR_LO_RAM_C && a < ADR_MID_LO)) begin
            r.target = TGT_RAM;
            r.ram_address = {bank_sel[0], a};
        end else if (a >= ADR_MID_LO && a <= ADR_MID_HI) begin
            r.target = TGT_RAM;
            r.ram_address = {bank_sel[1], a + MID_OFFSET};
            r.mirror_to_base = wr && !bank_sel[1] && a < ADR_MIRROR_END;
        end else if (a == ADR_REG_BANK || a == ADR_REG_MAP) begin
            r.target = TGT_REG;
            if (wr) begin
                if (a == ADR_REG_BANK)
                    bank_sel = d[SEL_W-1:0];
                else
                    map_sel = d[SEL_W-1:0];
            end else begin
                r.read_data = (a == ADR_REG_BANK) ? bank_sel : map_sel;
            end
        end else if (a >= ADR_HI_LO) begin
            use_ram = wr || map_sel == MAP_ALL_RAM ||
                      (map_sel != MAP_EPROM && a < ADR_HI_RAM_END);
            if (use_ram) begin
                // minus 0x8000 just clears bit 15; the top page ignores the bank bit
                r.target = TGT_RAM;
                r.ram_address = {bank_sel[0] && a < ADR_TOP_PAGE, 1'b0, a[14:0]};
            end else if (map_sel == MAP_BASE) begin
                r.target = TGT_BASE;
            end else begin
                r.target = TGT_ROM;
                r.rom_address = a[ROM_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(0, 9))
            0: return ADDR_W'($urandom_range(0, 31));
            1: return ADDR_W'($urandom_range(32, 16'h3FFF));
            2: return ADDR_W'($urandom_range(16'h4000, 16'h5FFF));
            3: return ADDR_W'($urandom_range(16'h6000, 16'hBEFF));
            4: return $urandom_range(0, 1) ? ADR_REG_MAP : ADR_REG_BANK;
            5: return ADDR_W'($urandom_range(16'hBF02, 16'hBFFF));
            6, 7: return ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
            8: return ADDR_W'($urandom_range(16'hFF00, 16'hFFFF));
            default: return ADDR_W'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic wr, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d, input bit typed, input result_t res);
        result_t pred;
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, a};
        s_tuser  <= wr;
        do @(posedge aclk); while (!s_tready);
        pred = decode_access(wr, a, d);
        if (pred.target == TGT_REG && wr)
            reg_writes++;
        if (pred.mirror_to_base)
            mirror_hits++;
        pending_decodes.push_back(typed ? res : pred);
        words_sent++;
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
            errors++;
        end
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_taken != hold_reqs) begin
            m_tready <= 1'b0;
            hold_left <= 60;
            holds_taken <= holds_taken + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_decodes.size() == 0) begin
                $display("%0t: unexpected word target %0h data %0h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = pending_decodes.pop_front();
                check_field("target", 32'(want.target), 32'(m_tuser));
                check_field("ram_address", 32'(want.ram_address), 32'(m_tdata[16:0]));
                check_field("rom_address", 32'(want.rom_address), 32'(m_tdata[30:17]));
                check_field("read_data", 32'(want.read_data), 32'(m_tdata[32:31]));
                check_field("mirror_to_base", 32'(want.mirror_to_base), 32'(m_tdata[33]));
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].wr, dir_rows[i].addr, dir_rows[i].data,
                      dir_rows[i].typed, dir_rows[i].res);

        // phases: free running, sender gaps, receiver stalls, light both, back-pressure
        for (int phase = 0; phase < 5; phase++) begin
            gap_pct   = (phase == 1) ? 54 : (phase == 3) ? 7 : 0;
            stall_pct = (phase == 2) ? 54 : (phase == 3) ? 7 : 0;
            for (int n = 0; n < ((phase == 4) ? 300 : 400); n++) begin
                if (phase == 4 && n % 100 == 10)
                    hold_reqs++;
                send_word(1'($urandom_range(0, 1)), pick_address(), DATA_W'($urandom),
                          1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        stall_pct = 0;

        while (pending_decodes.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("run: %0d bus accesses, %0d results, %0d register writes, %0d mirror writes",
                 words_sent, results_seen, reg_writes, mirror_hits);
        $display("run: all rom map and bank settings, idle and stall mixes, output back-pressure");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
